### rtl/apbb_pkg.sv
// Shared types, field widths and register indexes for the affine bounding-box core.
`timescale 1ns / 1ps
`default_nettype none

package apbb_pkg;

  // Fixed widths of the configuration words, vertex fields and box fields.
  localparam int CFG_W     = 32;
  localparam int VTX_W     = 32;
  localparam int BOX_W     = 17;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = CFG_W + VTX_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SKEW_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SKEW_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 3'd5;

  typedef logic signed [CFG_W-1:0] cfg_word_t;
  typedef logic signed [VTX_W-1:0] vtx_word_t;
  typedef logic signed [BOX_W-1:0] box_word_t;
  typedef logic [CFG_IDX_W-1:0]    cfg_index_t;

  // Linear part of the affine matrix.
  typedef struct packed {
    cfg_word_t scale_x;
    cfg_word_t skew_y;
    cfg_word_t skew_x;
    cfg_word_t scale_y;
  } matrix_t;

  // Translation applied to the box corners.
  typedef struct packed {
    cfg_word_t shift_x;
    cfg_word_t shift_y;
  } shift_t;

endpackage

`default_nettype wire

### rtl/apbb_if.sv
// Handshake interfaces for the vertex, box and configuration channels.
`timescale 1ns / 1ps
`default_nettype none

interface apbb_vertex_if;
  logic                valid;
  logic                ready;
  apbb_pkg::vtx_word_t vertex_x;
  apbb_pkg::vtx_word_t vertex_y;
  logic                last_vertex;

  modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface apbb_box_if;
  logic                valid;
  logic                ready;
  apbb_pkg::box_word_t box_left;
  apbb_pkg::box_word_t box_top;
  apbb_pkg::box_word_t box_right;
  apbb_pkg::box_word_t box_bottom;

  modport source (output valid, box_left, box_top, box_right, box_bottom, input ready);
  modport sink   (input valid, box_left, box_top, box_right, box_bottom, output ready);
endinterface

interface apbb_cfg_if;
  logic                 valid;
  logic                 ready;
  apbb_pkg::cfg_index_t index;
  apbb_pkg::cfg_word_t  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/apbb_transform.sv
// Pipelined matrix transform: vertex register, products, saturated products, saturated sums.
`timescale 1ns / 1ps
`default_nettype none

module apbb_transform #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire apbb_pkg::vtx_word_t     in_x,
  input  wire apbb_pkg::vtx_word_t     in_y,
  input  wire                          in_last,
  input  wire apbb_pkg::matrix_t       matrix,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_tx,
  output logic signed [COORD_WIDTH-1:0] out_ty,
  output logic                         out_last
);

  localparam int PW = apbb_pkg::PROD_W;
  localparam int SW = COORD_WIDTH + 1;

  localparam logic signed [PW-1:0] PROD_HI = (PW'(1) <<< (COORD_WIDTH - 1)) - PW'(1);
  localparam logic signed [PW-1:0] PROD_LO = ~PROD_HI;
  localparam logic signed [SW-1:0] SUM_HI  = (SW'(1) <<< (COORD_WIDTH - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SUM_LO  = ~SUM_HI;

  // Drop the fraction of an exact product, then clamp to the coordinate range.
  function automatic logic signed [COORD_WIDTH-1:0] sat_prod(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = p >>> FRAC_BITS;
    if (s > PROD_HI) begin
      sat_prod = PROD_HI[COORD_WIDTH-1:0];
    end else if (s < PROD_LO) begin
      sat_prod = PROD_LO[COORD_WIDTH-1:0];
    end else begin
      sat_prod = s[COORD_WIDTH-1:0];
    end
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] sat_sum(
    input logic signed [COORD_WIDTH-1:0] a,
    input logic signed [COORD_WIDTH-1:0] b
  );
    logic signed [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s > SUM_HI) begin
      sat_sum = SUM_HI[COORD_WIDTH-1:0];
    end else if (s < SUM_LO) begin
      sat_sum = SUM_LO[COORD_WIDTH-1:0];
    end else begin
      sat_sum = s[COORD_WIDTH-1:0];
    end
  endfunction

  // Stage 1: vertex register.
  logic                  v1;
  apbb_pkg::vtx_word_t   x1;
  apbb_pkg::vtx_word_t   y1;
  logic                  l1;
  // Stage 2: exact products.
  logic                  v2;
  logic signed [PW-1:0]  p_ax;
  logic signed [PW-1:0]  p_cy;
  logic signed [PW-1:0]  p_bx;
  logic signed [PW-1:0]  p_dy;
  logic                  l2;
  // Stage 3: products scaled back and saturated.
  logic                  v3;
  logic signed [COORD_WIDTH-1:0] q_ax;
  logic signed [COORD_WIDTH-1:0] q_cy;
  logic signed [COORD_WIDTH-1:0] q_bx;
  logic signed [COORD_WIDTH-1:0] q_dy;
  logic                  l3;

  apbb_pkg::cfg_word_t   m_a;
  apbb_pkg::cfg_word_t   m_b;
  apbb_pkg::cfg_word_t   m_c;
  apbb_pkg::cfg_word_t   m_d;
  logic signed [PW-1:0]  p_ax_next;
  logic signed [PW-1:0]  p_cy_next;
  logic signed [PW-1:0]  p_bx_next;
  logic signed [PW-1:0]  p_dy_next;

  logic free1, free2, free3, free4;

  assign free4    = !out_valid || out_ready;
  assign free3    = !v3 || free4;
  assign free2    = !v2 || free3;
  assign free1    = !v1 || free2;
  assign in_ready = free1;

  assign m_a = matrix.scale_x;
  assign m_b = matrix.skew_y;
  assign m_c = matrix.skew_x;
  assign m_d = matrix.scale_y;

  assign p_ax_next = PW'(m_a) * PW'(x1);
  assign p_cy_next = PW'(m_c) * PW'(y1);
  assign p_bx_next = PW'(m_b) * PW'(x1);
  assign p_dy_next = PW'(m_d) * PW'(y1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (free1) v1 <= in_valid;
      if (free2) v2 <= v1;
      if (free3) v3 <= v2;
      if (free4) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (free1) begin
      x1 <= in_x;
      y1 <= in_y;
      l1 <= in_last;
    end
    if (free2) begin
      p_ax <= p_ax_next;
      p_cy <= p_cy_next;
      p_bx <= p_bx_next;
      p_dy <= p_dy_next;
      l2   <= l1;
    end
    if (free3) begin
      q_ax <= sat_prod(p_ax);
      q_cy <= sat_prod(p_cy);
      q_bx <= sat_prod(p_bx);
      q_dy <= sat_prod(p_dy);
      l3   <= l2;
    end
    if (free4) begin
      out_tx   <= sat_sum(q_ax, q_cy);
      out_ty   <= sat_sum(q_bx, q_dy);
      out_last <= l3;
    end
  end

  // A product waiting on a full stage 3 must stay put.
  a_prod_hold: assert property (@(posedge clk) disable iff (rst)
    v2 && !free3 |=> v2 && $stable(p_ax) && $stable(p_dy))
    else $error("product stage changed while stalled");

endmodule

`default_nettype wire

### rtl/apbb_accum.sv
// Running minimum and maximum of the transformed vertices, with a corner register per mesh.
`timescale 1ns / 1ps
`default_nettype none

module apbb_accum #(
  parameter int COORD_WIDTH = 32
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire signed [COORD_WIDTH-1:0]  in_tx,
  input  wire signed [COORD_WIDTH-1:0]  in_ty,
  input  wire                           in_last,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic signed [COORD_WIDTH-1:0] min_x,
  output logic signed [COORD_WIDTH-1:0] min_y,
  output logic signed [COORD_WIDTH-1:0] max_x,
  output logic signed [COORD_WIDTH-1:0] max_y
);

  logic signed [COORD_WIDTH-1:0] min_x_acc;
  logic signed [COORD_WIDTH-1:0] min_y_acc;
  logic signed [COORD_WIDTH-1:0] max_x_acc;
  logic signed [COORD_WIDTH-1:0] max_y_acc;
  logic                          box_empty;

  logic signed [COORD_WIDTH-1:0] min_x_next;
  logic signed [COORD_WIDTH-1:0] min_y_next;
  logic signed [COORD_WIDTH-1:0] max_x_next;
  logic signed [COORD_WIDTH-1:0] max_y_next;

  logic free_c;
  logic take;

  // Only a closing vertex needs room in the corner register.
  assign free_c   = !out_valid || out_ready;
  assign in_ready = !in_last || free_c;
  assign take     = in_valid && in_ready;

  assign min_x_next = (box_empty || in_tx < min_x_acc) ? in_tx : min_x_acc;
  assign max_x_next = (box_empty || in_tx > max_x_acc) ? in_tx : max_x_acc;
  assign min_y_next = (box_empty || in_ty < min_y_acc) ? in_ty : min_y_acc;
  assign max_y_next = (box_empty || in_ty > max_y_acc) ? in_ty : max_y_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_x_acc <= '0;
      min_y_acc <= '0;
      max_x_acc <= '0;
      max_y_acc <= '0;
      box_empty <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (free_c) out_valid <= take && in_last;
      if (take) begin
        if (in_last) begin
          min_x_acc <= '0;
          min_y_acc <= '0;
          max_x_acc <= '0;
          max_y_acc <= '0;
          box_empty <= 1'b1;
        end else begin
          min_x_acc <= min_x_next;
          min_y_acc <= min_y_next;
          max_x_acc <= max_x_next;
          max_y_acc <= max_y_next;
          box_empty <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free_c && take && in_last) begin
      min_x <= min_x_next;
      min_y <= min_y_next;
      max_x <= max_x_next;
      max_y <= max_y_next;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    take && in_last |=> box_empty)
    else $error("accumulator not cleared after closing vertex");

  a_acc_ordered: assert property (@(posedge clk) disable iff (rst)
    !box_empty |-> (min_x_acc <= max_x_acc) && (min_y_acc <= max_y_acc))
    else $error("running minimum exceeds running maximum");

  a_corner_ordered: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (min_x <= max_x) && (min_y <= max_y))
    else $error("corner register holds an inverted box");

endmodule

`default_nettype wire

### rtl/apbb_finalize.sv
// Translation of the box corners, then floor and ceiling into the output register.
`timescale 1ns / 1ps
`default_nettype none

module apbb_finalize #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire signed [COORD_WIDTH-1:0] min_x,
  input  wire signed [COORD_WIDTH-1:0] min_y,
  input  wire signed [COORD_WIDTH-1:0] max_x,
  input  wire signed [COORD_WIDTH-1:0] max_y,
  input  wire apbb_pkg::shift_t        shift,
  output logic                         out_valid,
  input  wire                          out_ready,
  output apbb_pkg::box_word_t          box_left,
  output apbb_pkg::box_word_t          box_top,
  output apbb_pkg::box_word_t          box_right,
  output apbb_pkg::box_word_t          box_bottom
);

  localparam int SW = ((COORD_WIDTH > apbb_pkg::CFG_W) ? COORD_WIDTH : apbb_pkg::CFG_W) + 1;
  localparam int CW = ((COORD_WIDTH > FRAC_BITS + 1) ? COORD_WIDTH : FRAC_BITS + 1) + 1;

  localparam logic signed [SW-1:0] SUM_HI   = (SW'(1) <<< (COORD_WIDTH - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SUM_LO   = ~SUM_HI;
  localparam logic signed [CW-1:0] CEIL_ADD = (CW'(1) <<< FRAC_BITS) - CW'(1);

  function automatic logic signed [COORD_WIDTH-1:0] translate(
    input logic signed [COORD_WIDTH-1:0] v,
    input apbb_pkg::cfg_word_t           t
  );
    logic signed [SW-1:0] s;
    s = SW'(v) + SW'(t);
    if (s > SUM_HI) begin
      translate = SUM_HI[COORD_WIDTH-1:0];
    end else if (s < SUM_LO) begin
      translate = SUM_LO[COORD_WIDTH-1:0];
    end else begin
      translate = s[COORD_WIDTH-1:0];
    end
  endfunction

  function automatic apbb_pkg::box_word_t to_floor(input logic signed [COORD_WIDTH-1:0] v);
    logic signed [CW-1:0] s;
    s = CW'(v) >>> FRAC_BITS;
    to_floor = s[apbb_pkg::BOX_W-1:0];
  endfunction

  function automatic apbb_pkg::box_word_t to_ceil(input logic signed [COORD_WIDTH-1:0] v);
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] s;
    a = CW'(v) + CEIL_ADD;
    s = a >>> FRAC_BITS;
    to_ceil = s[apbb_pkg::BOX_W-1:0];
  endfunction

  logic                          vt;
  logic signed [COORD_WIDTH-1:0] t_min_x;
  logic signed [COORD_WIDTH-1:0] t_min_y;
  logic signed [COORD_WIDTH-1:0] t_max_x;
  logic signed [COORD_WIDTH-1:0] t_max_y;

  logic free_o;
  logic free_t;

  assign free_o   = !out_valid || out_ready;
  assign free_t   = !vt || free_o;
  assign in_ready = free_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      vt        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (free_t) vt <= in_valid;
      if (free_o) out_valid <= vt;
    end
  end

  always_ff @(posedge clk) begin
    if (free_t) begin
      t_min_x <= translate(min_x, shift.shift_x);
      t_min_y <= translate(min_y, shift.shift_y);
      t_max_x <= translate(max_x, shift.shift_x);
      t_max_y <= translate(max_y, shift.shift_y);
    end
    if (free_o) begin
      box_left   <= to_floor(t_min_x);
      box_top    <= to_floor(t_min_y);
      box_right  <= to_ceil(t_max_x);
      box_bottom <= to_ceil(t_max_y);
    end
  end

endmodule

`default_nettype wire

### rtl/affine_point_bounding_box_core.sv
// Top level of the transformed bounding-box core: configuration registers and pipeline.
//
//   Channel  Direction  Carries                                     Transaction when
//   vertex   in         vertex_x, vertex_y, last_vertex             valid && ready
//   box      out        box_left, box_top, box_right, box_bottom   valid && ready
//   cfg      in         index, data (register write)                valid && ready
//
// One vertex transaction is accepted every cycle unless a stalled box output backs up the pipeline; the four
// matrix products use four multipliers side by side, so nothing in the path iterates.
// The box for a mesh leaves the output register once the transaction of its
// closing vertex has passed the four transform stages, the corner register
// and the translation stage.
// Reset (synchronous, active high) empties the pipeline, clears the running
// box and restores the identity matrix with no translation.
// Each stage holds while the one below it is full, so a stalled box output
// still lets vertices fill the stages above it; the cfg channel is always ready.
`timescale 1ns / 1ps
`default_nettype none

module affine_point_bounding_box_core #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input wire          clk,
  input wire          rst,
  apbb_vertex_if.sink vertex,
  apbb_box_if.source  box,
  apbb_cfg_if.sink    cfg
);

  // Configuration registers; all are signed fixed point with FRAC_BITS fraction bits.
  apbb_pkg::matrix_t matrix;
  apbb_pkg::shift_t  shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix.scale_x <= apbb_pkg::cfg_word_t'(1) <<< FRAC_BITS;
      matrix.skew_y  <= '0;
      matrix.skew_x  <= '0;
      matrix.scale_y <= apbb_pkg::cfg_word_t'(1) <<< FRAC_BITS;
      shift.shift_x  <= '0;
      shift.shift_y  <= '0;
    end else if (cfg.valid && cfg.ready) begin
      // Writes to indexes past the last register are dropped.
      unique case (cfg.index)
        apbb_pkg::REG_SCALE_X: matrix.scale_x <= cfg.data;
        apbb_pkg::REG_SKEW_Y:  matrix.skew_y  <= cfg.data;
        apbb_pkg::REG_SKEW_X:  matrix.skew_x  <= cfg.data;
        apbb_pkg::REG_SCALE_Y: matrix.scale_y <= cfg.data;
        apbb_pkg::REG_SHIFT_X: shift.shift_x  <= cfg.data;
        apbb_pkg::REG_SHIFT_Y: shift.shift_y  <= cfg.data;
        default: ;
      endcase
    end
  end

  assign cfg.ready = 1'b1;

  // Transform pipeline to accumulator.
  logic                          xf_valid;
  logic                          xf_ready;
  logic signed [COORD_WIDTH-1:0] xf_tx;
  logic signed [COORD_WIDTH-1:0] xf_ty;
  logic                          xf_last;

  // Corner register to finishing stages.
  logic                          cr_valid;
  logic                          cr_ready;
  logic signed [COORD_WIDTH-1:0] cr_min_x;
  logic signed [COORD_WIDTH-1:0] cr_min_y;
  logic signed [COORD_WIDTH-1:0] cr_max_x;
  logic signed [COORD_WIDTH-1:0] cr_max_y;

  apbb_transform #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_transform (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vertex.valid),
    .in_ready  (vertex.ready),
    .in_x      (vertex.vertex_x),
    .in_y      (vertex.vertex_y),
    .in_last   (vertex.last_vertex),
    .matrix    (matrix),
    .out_valid (xf_valid),
    .out_ready (xf_ready),
    .out_tx    (xf_tx),
    .out_ty    (xf_ty),
    .out_last  (xf_last)
  );

  // Vertices that do not close a mesh are absorbed into the running box here.
  apbb_accum #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (xf_valid),
    .in_ready  (xf_ready),
    .in_tx     (xf_tx),
    .in_ty     (xf_ty),
    .in_last   (xf_last),
    .out_valid (cr_valid),
    .out_ready (cr_ready),
    .min_x     (cr_min_x),
    .min_y     (cr_min_y),
    .max_x     (cr_max_x),
    .max_y     (cr_max_y)
  );

  apbb_finalize #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_finalize (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (cr_valid),
    .in_ready   (cr_ready),
    .min_x      (cr_min_x),
    .min_y      (cr_min_y),
    .max_x      (cr_max_x),
    .max_y      (cr_max_y),
    .shift      (shift),
    .out_valid  (box.valid),
    .out_ready  (box.ready),
    .box_left   (box.box_left),
    .box_top    (box.box_top),
    .box_right  (box.box_right),
    .box_bottom (box.box_bottom)
  );

endmodule

`default_nettype wire

### tb/apbb_box_checker.sv
// Checker for the affine bounding-box core: predicts each mesh box and compares it.
`timescale 1ns / 1ps

module apbb_box_checker (
  input  wire    clk,
  input  wire    rst,
  apbb_vertex_if vertex,
  apbb_box_if    box,
  apbb_cfg_if    cfg,
  output int     err_count,
  output int     pending
);

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  typedef logic signed [63:0] wide_t;

  localparam wide_t SAT_HI   = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
  localparam wide_t SAT_LO   = -SAT_HI - 64'sd1;
  localparam wide_t FRAC_MSK = (64'sd1 <<< FRAC_BITS) - 64'sd1;

  typedef struct packed {
    apbb_pkg::box_word_t left;
    apbb_pkg::box_word_t top;
    apbb_pkg::box_word_t right;
    apbb_pkg::box_word_t bottom;
  } box_t;

  apbb_pkg::matrix_t mat;
  apbb_pkg::shift_t  shf;
  wide_t             lo_x, lo_y, hi_x, hi_y;
  logic              box_empty;
  box_t              owed_boxes[$];
  int                errors;

  function automatic wide_t clamp_coord(wide_t v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // Exact product, dropped fraction bits (toward minus infinity), then saturation.
  function automatic wide_t mul_q(apbb_pkg::cfg_word_t k, apbb_pkg::vtx_word_t v);
    wide_t p;
    p = wide_t'(k) * wide_t'(v);
    return clamp_coord(p >>> FRAC_BITS);
  endfunction

  function automatic apbb_pkg::box_word_t floor_int(wide_t v);
    wide_t f;
    f = v >>> FRAC_BITS;
    return f[apbb_pkg::BOX_W-1:0];
  endfunction

  function automatic apbb_pkg::box_word_t ceil_int(wide_t v);
    wide_t c;
    c = (v + FRAC_MSK) >>> FRAC_BITS;
    return c[apbb_pkg::BOX_W-1:0];
  endfunction

  task automatic clear_corners();
    lo_x      = '0;
    lo_y      = '0;
    hi_x      = '0;
    hi_y      = '0;
    box_empty = 1'b1;
  endtask

  task automatic report(string msg);
    $display("%0t apbb_box_checker: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, apbb_pkg::box_word_t got,
                             apbb_pkg::box_word_t want);
    if (got !== want)
      report($sformatf("%s is %0d, predicted %0d", name, got, want));
  endtask

  // Transforms one vertex, widens the running box and, on the closing
  // vertex, queues the translated integer box.
  task automatic absorb_vertex(apbb_pkg::vtx_word_t x, apbb_pkg::vtx_word_t y,
                               logic closing);
    wide_t tx, ty;
    box_t  b;
    tx = clamp_coord(mul_q(mat.scale_x, x) + mul_q(mat.skew_x, y));
    ty = clamp_coord(mul_q(mat.skew_y, x) + mul_q(mat.scale_y, y));
    if (box_empty) begin
      lo_x      = tx;
      hi_x      = tx;
      lo_y      = ty;
      hi_y      = ty;
      box_empty = 1'b0;
    end else begin
      if (tx < lo_x) lo_x = tx;
      if (tx > hi_x) hi_x = tx;
      if (ty < lo_y) lo_y = ty;
      if (ty > hi_y) hi_y = ty;
    end
    if (closing) begin
      b.left   = floor_int(clamp_coord(lo_x + wide_t'(shf.shift_x)));
      b.top    = floor_int(clamp_coord(lo_y + wide_t'(shf.shift_y)));
      b.right  = ceil_int(clamp_coord(hi_x + wide_t'(shf.shift_x)));
      b.bottom = ceil_int(clamp_coord(hi_y + wide_t'(shf.shift_y)));
      owed_boxes.push_back(b);
      clear_corners();
    end
  endtask

  always @(posedge clk) begin
    box_t want;
    if (rst) begin
      mat.scale_x = 32'sd1 <<< FRAC_BITS;
      mat.skew_y  = '0;
      mat.skew_x  = '0;
      mat.scale_y = 32'sd1 <<< FRAC_BITS;
      shf         = '0;
      owed_boxes.delete();
      clear_corners();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          apbb_pkg::REG_SCALE_X: mat.scale_x = cfg.data;
          apbb_pkg::REG_SKEW_Y:  mat.skew_y  = cfg.data;
          apbb_pkg::REG_SKEW_X:  mat.skew_x  = cfg.data;
          apbb_pkg::REG_SCALE_Y: mat.scale_y = cfg.data;
          apbb_pkg::REG_SHIFT_X: shf.shift_x = cfg.data;
          apbb_pkg::REG_SHIFT_Y: shf.shift_y = cfg.data;
          default: ;
        endcase
      end
      if (vertex.valid && vertex.ready)
        absorb_vertex(vertex.vertex_x, vertex.vertex_y, vertex.last_vertex);
      if (box.valid && box.ready) begin
        if (owed_boxes.size() == 0) begin
          report($sformatf("box transaction (%0d,%0d,%0d,%0d) with no mesh closed",
                           box.box_left, box.box_top, box.box_right, box.box_bottom));
        end else begin
          want = owed_boxes.pop_front();
          check_field("box_left", box.box_left, want.left);
          check_field("box_top", box.box_top, want.top);
          check_field("box_right", box.box_right, want.right);
          check_field("box_bottom", box.box_bottom, want.bottom);
        end
      end
    end
    err_count <= errors;
    pending   <= owed_boxes.size();
  end

endmodule

### tb/tb_affine_point_bounding_box_core.sv
// Stimulus and verdict for the affine bounding-box core, with the box checker beside it.
`timescale 1ns / 1ps

module tb_affine_point_bounding_box_core;

  // Indexes past the last register; writes to them must change nothing.
  localparam apbb_pkg::cfg_index_t REG_SPARE_6 = 3'd6;
  localparam apbb_pkg::cfg_index_t REG_SPARE_7 = 3'd7;

  // Once every owed box has left the core, this drain leaves it idle with
  // room to spare.
  localparam int DRAIN_CYCLES = 24;
  // Roughly 550 vertices, even under the heaviest idling and with the drains
  // between phases, stay far below this ceiling.
  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_VERTICES = 62;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic clk;
  logic rst;
  int   gap_pct;
  int   stall_pct;
  int   cycles;
  int   err_count;
  int   boxes_owed;

  apbb_vertex_if vertex_ch ();
  apbb_box_if    box_ch ();
  apbb_cfg_if    cfg_ch ();

  affine_point_bounding_box_core u_top (
    .clk    (clk),
    .rst    (rst),
    .vertex (vertex_ch),
    .box    (box_ch),
    .cfg    (cfg_ch)
  );

  apbb_box_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .vertex    (vertex_ch),
    .box       (box_ch),
    .cfg       (cfg_ch),
    .err_count (err_count),
    .pending   (boxes_owed)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Every input starts at a known value before the first clock edge.
  initial begin
    rst                   = 1'b1;
    gap_pct               = 0;
    stall_pct             = 0;
    vertex_ch.valid       = 1'b0;
    vertex_ch.vertex_x    = '0;
    vertex_ch.vertex_y    = '0;
    vertex_ch.last_vertex = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = '0;
    cfg_ch.data           = '0;
    box_ch.ready          = 1'b0;
  end

  // The box receiver stalls at random with the probability of the current phase.
  always @(posedge clk)
    box_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

  // A run that hangs, for instance on a box that never comes out, ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_affine_point_bounding_box_core: done, errors");
      $finish;
    end
  end

  task automatic set_idle(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      IDLE_SENDER: begin
        gap_pct   = 46;
        stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        gap_pct   = 0;
        stall_pct = 46;
      end
      default: begin
        gap_pct   = 18;
        stall_pct = 18;
      end
    endcase
  endtask

  // Offers one vertex after a random number of idle cycles and holds it
  // until the core takes it. Valid stays high so back-to-back vertices
  // follow without a gap.
  task automatic drive_vertex(apbb_pkg::vtx_word_t x, apbb_pkg::vtx_word_t y,
                              logic closing);
    while ($urandom_range(0, 99) < gap_pct) begin
      vertex_ch.valid <= 1'b0;
      @(posedge clk);
    end
    vertex_ch.valid       <= 1'b1;
    vertex_ch.vertex_x    <= x;
    vertex_ch.vertex_y    <= y;
    vertex_ch.last_vertex <= closing;
    do @(posedge clk); while (!vertex_ch.ready);
  endtask

  task automatic write_reg(apbb_pkg::cfg_index_t idx, apbb_pkg::cfg_word_t val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Writes all six registers, then a junk word to an unused index, which
  // the core must ignore. Only called while the core is idle.
  task automatic load_matrix(apbb_pkg::cfg_word_t a, apbb_pkg::cfg_word_t b,
                             apbb_pkg::cfg_word_t c, apbb_pkg::cfg_word_t d,
                             apbb_pkg::cfg_word_t sx, apbb_pkg::cfg_word_t sy);
    write_reg(apbb_pkg::REG_SCALE_X, a);
    write_reg(apbb_pkg::REG_SKEW_Y, b);
    write_reg(apbb_pkg::REG_SKEW_X, c);
    write_reg(apbb_pkg::REG_SCALE_Y, d);
    write_reg(apbb_pkg::REG_SHIFT_X, sx);
    write_reg(apbb_pkg::REG_SHIFT_Y, sy);
    write_reg($urandom_range(0, 1) ? REG_SPARE_7 : REG_SPARE_6,
              apbb_pkg::cfg_word_t'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  // Drops valid, lets the checker see the last transaction, waits for every
  // owed box and then lets the pipeline drain completely.
  task automatic settle();
    vertex_ch.valid <= 1'b0;
    @(posedge clk);
    while (boxes_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic apbb_pkg::cfg_word_t pick_edge();
    case ($urandom_range(0, 4))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sh0000_0000;
      3: return 32'shFFFF_FFFF;
      default: return 32'sh0001_0000;
    endcase
  endfunction

  // Mostly coordinates within +/-128.0 so that boxes stay meaningful,
  // with full-range words and extremes mixed in.
  function automatic apbb_pkg::vtx_word_t pick_coord();
    case ($urandom_range(0, 9))
      0: return pick_edge();
      1, 2: return apbb_pkg::vtx_word_t'($urandom);
      default: return apbb_pkg::vtx_word_t'($urandom_range(0, 32'h0100_0000))
                      - 32'sh0080_0000;
    endcase
  endfunction

  // Mostly matrix entries and shifts within +/-4.0; full-range and extreme
  // values exercise the product and translation saturation.
  function automatic apbb_pkg::cfg_word_t pick_coeff();
    case ($urandom_range(0, 9))
      0: return pick_edge();
      1, 2: return apbb_pkg::cfg_word_t'($urandom);
      default: return apbb_pkg::cfg_word_t'($urandom_range(0, 32'h0008_0000))
                      - 32'sh0004_0000;
    endcase
  endfunction

  initial begin
    int mesh_len;
    int sent;

    cycles = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idle(IDLE_BOTH);

    // Identity matrix from reset. A single vertex forms a whole mesh and
    // is loaded as both corners.
    drive_vertex(32'sh0000_0000, 32'sh0000_0000, 1'b1);
    // Fractional corners: floor and ceiling go opposite ways.
    drive_vertex(32'sh0001_8000, 32'shFFFE_8000, 1'b1);
    // Coordinate extremes; the ceiling of the largest value is 32768.
    drive_vertex(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    drive_vertex(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
    // A short mesh with mixed signs and odd fractions.
    drive_vertex(32'sh0001_0000, 32'sh0002_0000, 1'b0);
    drive_vertex(32'shFFFD_0001, 32'sh0000_0005, 1'b0);
    drive_vertex(32'shFFFF_FFFF, 32'shFFFF_FFFF, 1'b0);
    drive_vertex(32'sh1234_5678, 32'shEDCB_A987, 1'b1);
    settle();

    // Extreme matrix and translation: products, their sums and the
    // translated corners all saturate.
    load_matrix(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                32'sh7FFF_FFFF, 32'sh8000_0000);
    drive_vertex(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
    drive_vertex(32'sh8000_0000, 32'sh8000_0000, 1'b1);
    drive_vertex(32'sh0001_0000, 32'sh0000_0000, 1'b0);
    drive_vertex(32'sh0000_0000, 32'shFFFF_0000, 1'b1);
    drive_vertex(32'sh0000_0001, 32'shFFFF_FFFF, 1'b1);
    settle();

    // Mixed scales and skews with the translation at the opposite extremes.
    load_matrix(32'sh0000_8000, 32'shFFFF_0000, 32'sh0002_0000, 32'shFFFF_C000,
                32'sh8000_0000, 32'sh7FFF_FFFF);
    drive_vertex(32'sh0003_4000, 32'shFFF0_0001, 1'b0);
    drive_vertex(32'sh8000_0000, 32'sh0000_0000, 1'b0);
    drive_vertex(32'sh0000_0000, 32'sh7FFF_FFFF, 1'b1);
    drive_vertex(32'shFFFF_8000, 32'sh0000_8000, 1'b1);
    settle();

    // Random phases: each one sets a fresh configuration, then streams
    // well-formed meshes of random length and content, always closed so
    // that no mesh straddles a register write.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_idle(idle_mode_e'(phase % 4));
      load_matrix(pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff(),
                  pick_coeff(), pick_coeff());
      sent = 0;
      while (sent < PHASE_VERTICES) begin
        mesh_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        for (int i = 0; i < mesh_len; i++) begin
          drive_vertex(pick_coord(), pick_coord(), i == mesh_len - 1);
          sent++;
        end
      end
      settle();
    end

    if (err_count == 0)
      $display("tb_affine_point_bounding_box_core: done, clean");
    else
      $display("tb_affine_point_bounding_box_core: done, errors");
    $finish;
  end

endmodule
